FILE: src/wmmf_pkg.sv
// Package of shared types and constants for the window mean/median filter.
`default_nettype none
package wmmf_pkg;

	localparam int DEF_MAX_KERNEL = 7;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_KW   = 3'd1;
	localparam logic [2:0] REG_KH   = 3'd2;
	localparam logic [2:0] REG_IW   = 3'd3;
	localparam logic [2:0] REG_IH   = 3'd4;

	localparam logic MODE_MEAN   = 1'b0;
	localparam logic MODE_MEDIAN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} wmmf_state_t;

endpackage
`default_nettype wire

FILE: src/window_mean_median_filter.sv
// Usage: 8-bit grey pixels enter in raster order on the s_ stream, one per beat.
// Results leave on the m_ stream: tdata holds filtered, out_col, out_row (low bit
// up), tlast marks the last filtered pixel of the image, tuser flags a bad kernel.
// Border pixels produce no beat. The cfg channel writes registers by index:
// 0 mode, 1 kernel width, 2 kernel height, 3 image width, 4 image height; write
// only while the block is idle. cfg_ready is always high.
// Timing: one pixel at a time. A pixel is accepted, then the line store read
// data loads the window; a pixel with no result then frees the input. A mean
// result accumulates all MAX_KERNEL window rows, then runs a bit-serial divide
// by the kernel area over the SUMW-bit sum (14 bits at defaults). A median
// result runs 8 bit passes, each counting all MAX_KERNEL window rows. A bad
// kernel skips the line store and goes straight to the result beat.
// The line store is one RAM word per column holding MAX_KERNEL-1 rows.
// Reset clears the column and row counters, window and config registers (mean,
// 3x3, 1024x1024); the line store needs no clear. A stalled receiver holds the
// result register; a stall blocks input only once a further result is waiting.
`default_nettype none
module window_mean_median_filter #(
	parameter int MAX_KERNEL = wmmf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = wmmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wmmf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] pixel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [7:0] filtered, [17:8] out_col, [27:18] out_row
	output logic             m_tlast,   // frame_last
	output logic             m_tuser,   // [0] config_error
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	import wmmf_pkg::*;

	localparam int K    = MAX_KERNEL;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int DW0  = $clog2(MAX_WIDTH + 1);
	localparam int DH0  = $clog2(MAX_HEIGHT + 1);
	localparam int DW   = (DW0 > 11) ? DW0 : 11;
	localparam int DH   = (DH0 > 11) ? DH0 : 11;
	localparam int KRW  = $clog2(K);
	localparam int ARW  = $clog2(K * K + 1);
	localparam int SUMW = $clog2(K * K * 255 + 1);
	localparam int DCW  = $clog2(SUMW + 1);
	localparam int LSW  = 8 * (K - 1);

	// configuration
	logic        mode_q;
	logic [2:0]  kw_q, kh_q;
	logic [10:0] iw_q, ih_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MEAN;
			kw_q   <= 3'd3;
			kh_q   <= 3'd3;
			iw_q   <= 11'd1024;
			ih_q   <= 11'd1024;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_KW:   kw_q   <= cfg_data[2:0];
				REG_KH:   kh_q   <= cfg_data[2:0];
				REG_IW:   iw_q   <= cfg_data;
				REG_IH:   ih_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [DW-1:0] w_eff;
	logic [DH-1:0] h_eff;
	logic          bad_kernel;
	logic [ARW-1:0] area;

	always_comb begin
		w_eff = (DW'(iw_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(iw_q);
		h_eff = (DH'(ih_q) > DH'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT) : DH'(ih_q);
		bad_kernel = !kw_q[0] || !kh_q[0] || (DW'(kw_q) > w_eff) || (DH'(kh_q) > h_eff)
			|| (int'(kw_q) > K) || (int'(kh_q) > K);
		area = ARW'(kw_q * kh_q);
	end

	// state and datapath registers
	wmmf_state_t state_q, state_d;
	logic [7:0]      px_q;
	logic            err_q, last_q;
	logic [9:0]      ocol_q, orow_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [7:0]      win_q [K][K];
	logic [KRW-1:0]  rc_q;
	logic [SUMW-1:0] acc_q;
	logic [ARW-1:0]  cnt_q;
	logic [ARW-1:0]  rem_q;
	logic [DCW-1:0]  dcnt_q;
	logic [7:0]      prefix_q;
	logic [2:0]      bit_q;

	logic [LSW-1:0]  ls_rdata;
	logic            ls_we;
	logic            emit;
	logic            row_end;
	logic            calc_end;
	logic            out_free;

	assign out_free = !m_tvalid || m_tready;
	assign calc_end = (rc_q == KRW'(K - 1));

	always_comb begin
		emit    = (DW'(col_q) >= DW'(kw_q) - DW'(1)) && (DH'(row_q) >= DH'(kh_q) - DH'(1));
		row_end = (DW'(col_q) + DW'(1) >= w_eff);
	end

	// one row of the window per cycle: sum and count below threshold
	logic [7:0]      thr;
	logic [SUMW-1:0] row_sum;
	logic [ARW-1:0]  row_lt;
	logic [ARW-1:0]  cnt_tot;
	logic            row_on;

	always_comb begin
		thr     = prefix_q | (8'd1 << bit_q);
		row_on  = (KRW'(kh_q) > rc_q);
		row_sum = '0;
		row_lt  = '0;
		for (int c = 0; c < K; c++) begin
			if (row_on && (c >= K - int'(kw_q))) begin
				row_sum = row_sum + SUMW'(win_q[rc_q][c]);
				if (win_q[rc_q][c] < thr) begin
					row_lt = row_lt + ARW'(1);
				end
			end
		end
		cnt_tot = cnt_q + row_lt;
	end

	// restoring divide step
	logic [ARW:0] div_tmp;
	logic         div_ge;
	always_comb begin
		div_tmp = {rem_q, acc_q[SUMW-1]};
		div_ge  = (div_tmp >= {1'b0, area});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ls_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = bad_kernel ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				ls_we   = 1'b1;
				state_d = emit ? ST_CALC : ST_IDLE;
			end
			ST_CALC: begin
				if (calc_end) begin
					if (mode_q == MODE_MEAN) begin
						state_d = ST_DIV;
					end else if (bit_q == 3'd0) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (dcnt_q == DCW'(SUMW - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			err_q  <= 1'b0;
			for (int r = 0; r < K; r++) begin
				for (int c = 0; c < K; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (state_q == ST_IDLE && s_tvalid) begin
				err_q <= bad_kernel;
			end
			if (state_q == ST_READ) begin
				for (int r = 0; r < K; r++) begin
					for (int c = 0; c < K - 1; c++) begin
						win_q[r][c] <= win_q[r][c + 1];
					end
				end
				win_q[0][K - 1] <= px_q;
				for (int r = 1; r < K; r++) begin
					win_q[r][K - 1] <= ls_rdata[8 * (r - 1) +: 8];
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= (DH'(row_q) + DH'(1) >= h_eff) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	logic [DW-1:0] ocol_w;
	logic [DH-1:0] orow_w;
	always_comb begin
		ocol_w = DW'(col_q) - DW'(kw_q >> 1);
		orow_w = DH'(row_q) - DH'(kh_q >> 1);
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			px_q <= s_tdata;
		end
		if (state_q == ST_READ) begin
			ocol_q   <= ocol_w[9:0];
			orow_q   <= orow_w[9:0];
			last_q   <= row_end && (DH'(row_q) + DH'(1) >= h_eff);
			rc_q     <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			prefix_q <= '0;
			bit_q    <= 3'd7;
		end
		if (state_q == ST_CALC) begin
			if (mode_q == MODE_MEAN) begin
				acc_q <= acc_q + row_sum;
				rc_q  <= rc_q + KRW'(1);
				rem_q  <= '0;
				dcnt_q <= '0;
			end else if (calc_end) begin
				if (cnt_tot <= (area >> 1)) begin
					prefix_q <= thr;
				end
				bit_q <= bit_q - 3'd1;
				rc_q  <= '0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_tot;
				rc_q  <= rc_q + KRW'(1);
			end
		end
		if (state_q == ST_DIV) begin
			dcnt_q <= dcnt_q + DCW'(1);
			rem_q  <= div_ge ? ARW'(div_tmp - {1'b0, area}) : div_tmp[ARW-1:0];
			acc_q  <= {acc_q[SUMW-2:0], div_ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (err_q) begin
				m_tdata <= '0;
				m_tlast <= 1'b0;
				m_tuser <= 1'b1;
			end else begin
				m_tdata <= {4'd0, orow_q, ocol_q,
					(mode_q == MODE_MEAN) ? acc_q[7:0] : prefix_q};
				m_tlast <= last_q;
				m_tuser <= 1'b0;
			end
		end
	end

	wmmf_ram #(
		.WIDTH(LSW),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ls_we),
		.waddr(col_q),
		.wdata({ls_rdata[LSW-9:0], px_q}),
		.raddr(col_q),
		.rdata(ls_rdata)
	);

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("error beat carries data");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ && !emit |=> state_q == ST_IDLE && !$stable(col_q) || row_end)
		else $error("pixel without result did not retire");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && m_tvalid && !m_tready |=> state_q == ST_DONE)
		else $error("result dropped under stall");
`endif

endmodule
`default_nettype wire

FILE: src/wmmf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wmmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sim/tb_window_mean_median_filter.sv
// Testbench for the window mean/median filter: random streams checked against a scoreboard.
`default_nettype none
module tb_window_mean_median_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import wmmf_pkg::*;

	typedef struct {
		logic [7:0] filtered;
		logic [9:0] col;
		logic [9:0] row;
		logic       last;
		logic       err;
	} pix_result_t;

	class filter_scoreboard;
		logic [7:0]  lines [6][1024];
		logic [7:0]  win [7][7];
		int          col_cnt, row_cnt;
		logic        mode;
		logic [2:0]  kwid, khgt;
		logic [10:0] iwid, ihgt;
		pix_result_t expected_px [$];
		int          errors;

		function new();
			foreach (lines[r, c]) lines[r][c] = '0;
			foreach (win[r, c]) win[r][c] = '0;
			col_cnt = 0; row_cnt = 0; errors = 0;
			mode = MODE_MEAN; kwid = 3; khgt = 3; iwid = 1024; ihgt = 1024;
		endfunction

		function int eff_w();
			return iwid > 1024 ? 1024 : int'(iwid);
		endfunction

		function int eff_h();
			return ihgt > 1024 ? 1024 : int'(ihgt);
		endfunction

		function void write_reg(logic [2:0] idx, logic [10:0] val);
			case (idx)
				REG_MODE: mode = val[0];
				REG_KW:   kwid = val[2:0];
				REG_KH:   khgt = val[2:0];
				REG_IW:   iwid = val;
				REG_IH:   ihgt = val;
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [7:0] px);
			int w, h, kw, kh, col, sum, n, j;
			int vals [49];
			int v;
			pix_result_t e;
			w = eff_w(); h = eff_h(); kw = kwid; kh = khgt;
			e.filtered = '0; e.col = '0; e.row = '0; e.last = 1'b0; e.err = 1'b0;
			if (kw % 2 == 0 || kh % 2 == 0 || kw > w || kh > h) begin
				e.err = 1'b1;
				expected_px.push_back(e);
				return;
			end
			col = col_cnt % 1024;
			for (int r = 0; r < 7; r++)
				for (int c = 0; c < 6; c++)
					win[r][c] = win[r][c + 1];
			win[0][6] = px;
			for (int r = 1; r < 7; r++)
				win[r][6] = lines[r - 1][col];
			for (int r = 5; r > 0; r--)
				lines[r][col] = lines[r - 1][col];
			lines[0][col] = px;
			if (col_cnt >= kw - 1 && row_cnt >= kh - 1) begin
				sum = 0; n = 0;
				for (int r = 0; r < kh; r++)
					for (int c = 7 - kw; c < 7; c++) begin
						v = win[r][c];
						sum += v;
						j = n;
						while (j > 0 && vals[j - 1] > v) begin
							vals[j] = vals[j - 1];
							j--;
						end
						vals[j] = v;
						n++;
					end
				e.filtered = (mode == MODE_MEDIAN) ? 8'(vals[n / 2]) : 8'(sum / (kw * kh));
				e.col = 10'(col_cnt - (kw - 1) / 2);
				e.row = 10'(row_cnt - (kh - 1) / 2);
				e.last = (col_cnt + 1 >= w && row_cnt + 1 >= h);
				expected_px.push_back(e);
			end
			if (col_cnt + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
			end else begin
				col_cnt++;
			end
		endfunction

		function void check_result(logic [31:0] data, logic last, logic user);
			pix_result_t e;
			if (expected_px.size() == 0) begin
				$display("%0t: unexpected beat, actual data %h last %b err %b",
					$time, data, last, user);
				errors++;
				return;
			end
			e = expected_px.pop_front();
			if (data[7:0] !== e.filtered) begin
				$display("%0t: filtered expected %0d actual %0d", $time, e.filtered, data[7:0]);
				errors++;
			end
			if (data[17:8] !== e.col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, e.col, data[17:8]);
				errors++;
			end
			if (data[27:18] !== e.row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, e.row, data[27:18]);
				errors++;
			end
			if (data[31:28] !== 4'd0) begin
				$display("%0t: pad bits expected 0 actual %h", $time, data[31:28]);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: frame_last expected %b actual %b", $time, e.last, last);
				errors++;
			end
			if (user !== e.err) begin
				$display("%0t: config_error expected %b actual %b", $time, e.err, user);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	filter_scoreboard pix_sb = new();
	int n_pixels_in = 0;
	int n_writes = 0;
	int burst_left = 0;

	logic [7:0] u_dummy_px [9] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1,
		8'd254, 8'd128, 8'd0};

	always #4 clk = ~clk;

	window_mean_median_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			pix_sb.write_reg(cfg_index, cfg_data);
			n_writes++;
		end
		if (s_tvalid && s_tready) begin
			pix_sb.note_pixel(s_tdata);
			n_pixels_in++;
		end
		if (m_tvalid && m_tready)
			pix_sb.check_result(m_tdata, m_tlast, m_tuser);
	end

	// receiver: random stalls, with quiet stretches of steady ready
	int stall_left = 0;
	int rx_cycle = 0;
	always @(negedge clk) begin
		rx_cycle++;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if ((rx_cycle / 500) % 3 != 2 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 6);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
		int target;
		target = n_writes + 1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (n_writes < target);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [7:0] px);
		int target;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		target = n_pixels_in + 1;
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(negedge clk); while (n_pixels_in < target);
	endtask

	// hold input until every result is out, then let in-flight pixels drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pix_sb.expected_px.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [2:0] pick_kernel();
		return $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(0, 3) * 2 + 1);
	endfunction

	function automatic logic [10:0] pick_size(input int hi);
		case ($urandom_range(0, 19))
			0: return 11'd1024;
			1: return 11'($urandom_range(1025, 2047));
			2: return 11'd0;
			default: return 11'($urandom_range(1, hi));
		endcase
	endfunction

	task automatic random_phase();
		logic [10:0] new_w;
		int w, h, kw, kh, n, rem;
		wait_idle();
		if ($urandom_range(0, 2) != 0) write_reg(REG_MODE, 11'($urandom_range(0, 1)));
		if ($urandom_range(0, 2) != 0) write_reg(REG_KW, 11'(pick_kernel()));
		if ($urandom_range(0, 2) != 0) write_reg(REG_KH, 11'(pick_kernel()));
		if ($urandom_range(0, 2) != 0) begin
			new_w = pick_size(24);
			// widen only at the top of a frame so no window reads unwritten columns
			if ((new_w > 1024 ? 1024 : int'(new_w)) <= pix_sb.eff_w() || pix_sb.row_cnt == 0)
				write_reg(REG_IW, new_w);
		end
		if ($urandom_range(0, 2) != 0) write_reg(REG_IH, pick_size(12));
		w = pix_sb.eff_w(); h = pix_sb.eff_h(); kw = pix_sb.kwid; kh = pix_sb.khgt;
		if (kw % 2 == 0 || kh % 2 == 0 || kw > w || kh > h) begin
			n = $urandom_range(1, 4);
		end else begin
			rem = (pix_sb.row_cnt < h && pix_sb.col_cnt < w)
				? (h - pix_sb.row_cnt) * w - pix_sb.col_cnt : 0;
			if (rem > 0 && rem <= 200 && $urandom_range(0, 9) < 7)
				n = rem;
			else
				n = $urandom_range(1, 60);
		end
		repeat (n) send_pixel(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reset setting: 1024x1024 image, no window fits yet
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd128);
		// shrink under the stale column count, then a 3x3 image in median mode
		wait_idle();
		write_reg(REG_MODE, 11'(MODE_MEDIAN));
		write_reg(REG_KW, 11'd3);
		write_reg(REG_KH, 11'd3);
		write_reg(REG_IW, 11'd3);
		write_reg(REG_IH, 11'd3);
		foreach (u_dummy_px[i]) send_pixel(u_dummy_px[i]);
		wait_idle();
		write_reg(REG_MODE, 11'(MODE_MEAN));
		repeat (9) send_pixel(8'd255);
		// even kernel flags an error on every pixel
		wait_idle();
		write_reg(REG_KW, 11'd2);
		send_pixel(8'd7);
		send_pixel(8'd200);
		while (n_pixels_in < 950) random_phase();
		wait_idle();
		repeat (100) @(negedge clk);
		if (pix_sb.expected_px.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pix_sb.expected_px.size());
			pix_sb.errors++;
		end
		if (pix_sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
